// ===== src/png_pkg.sv =====
`default_nettype none
package png_pkg;

    // Register map (register index is paddr[2])
    localparam logic REG_AMPLITUDE = 1'b0;
    localparam logic REG_SEED      = 1'b1;

    localparam logic [14:0] AMP_RESET  = 15'h7FFF;
    localparam logic [31:0] SEED_RESET = 32'd1;

    localparam int NUM_STATES = 7;
    localparam logic [2:0] DIFF_IDX = 3'd6;

    // Multiply schedule, one product per step
    localparam logic [3:0] STEP_NORM       = 4'd0;
    localparam logic [3:0] STEP_POLE_FIRST = 4'd1;
    localparam logic [3:0] STEP_POLE_LAST  = 4'd12;
    localparam logic [3:0] STEP_DIRECT     = 4'd13;
    localparam logic [3:0] STEP_DIFF       = 4'd14;
    localparam logic [3:0] STEP_SCALE      = 4'd15;

    typedef struct packed {
        logic       issue;
        logic [3:0] step;
    } t_dp_ctrl;

    // Coefficient used by each step; the scale step takes amp instead
    function automatic logic signed [15:0] coef(input logic [3:0] step);
        logic signed [15:0] c;
        unique case (step)
            4'd0:    c = 16'sd4227;
            4'd1:    c = 16'sd32730;
            4'd2:    c = 16'sd1820;
            4'd3:    c = 16'sd32552;
            4'd4:    c = 16'sd2460;
            4'd5:    c = 16'sd31752;
            4'd6:    c = 16'sd5038;
            4'd7:    c = 16'sd28393;
            4'd8:    c = 16'sd10175;
            4'd9:    c = 16'sd18022;
            4'd10:   c = 16'sd17464;
            4'd11:   c = -16'sd24961;
            4'd12:   c = -16'sd553;
            4'd13:   c = 16'sd17569;
            4'd14:   c = 16'sd3798;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

    // One xorshift32 advance (13, 17, 5)
    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage
`default_nettype wire

// ===== src/png_in_if.sv =====
`default_nettype none
interface png_in_if;
    logic valid;
    logic ready;
    logic last_of_block;

    modport source (output valid, output last_of_block, input ready);
    modport sink   (input valid, input last_of_block, output ready);
endinterface
`default_nettype wire

// ===== src/png_out_if.sv =====
`default_nettype none
interface png_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               block_end;

    modport source (output valid, output sample, output block_end, input ready);
    modport sink   (input valid, input sample, input block_end, output ready);
endinterface
`default_nettype wire

// ===== src/pink_noise_generator_top.sv =====
`default_nettype none
// Pink noise generator. Each input beat yields one signed Q15 sample on the
// output channel, with last_of_block echoed as block_end. An item runs 16
// passes through a single 24x16 multiplier (amplitude normalization, six
// pole filters with two products each, direct term, differentiator, final
// scaling). Around those passes are the accept, the drain of the last
// product through the accumulate stage, the sequencer seeing the result,
// and a handoff into the output register; a full output register that is
// not drained stalls the handoff. i_in.ready is low while an item is in
// flight, so a new beat is only taken after the handoff. A finished sample
// waits in the output register while the next item is accepted. Registers
// over APB: amplitude at 0x0 (15 bits, Q15), seed at 0x4 (32 bits). Writing
// seed reloads the generator at once, and a zero seed loads 1. Write
// registers only while idle.
module pink_noise_generator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    png_in_if.sink           i_in,
    png_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state             r_state;
    logic [14:0]        r_amplitude;
    logic [31:0]        r_seed;
    logic [31:0]        r_rng;
    logic signed [15:0] r_white;
    logic [3:0]         r_step;
    logic               r_issuing;
    logic               r_last;
    logic               r_out_valid;
    logic signed [15:0] r_sample;
    logic               r_block_end;

    png_pkg::t_dp_ctrl  dp_ctrl;
    logic signed [15:0] dp_y;
    logic               dp_y_vld;
    logic               cfg_wr;
    logic               in_beat;
    logic               out_free;
    logic [31:0]        rng_next;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_beat  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign rng_next = png_pkg::xorshift(r_rng);

    // Register readback
    always_comb begin
        unique case (paddr[2])
            png_pkg::REG_AMPLITUDE: prdata = {17'd0, r_amplitude};
            default:                prdata = r_seed;
        endcase
    end

    // Config registers and white noise source
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= png_pkg::AMP_RESET;
            r_seed      <= png_pkg::SEED_RESET;
            r_rng       <= png_pkg::SEED_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                png_pkg::REG_AMPLITUDE: r_amplitude <= pwdata[14:0];
                default: begin
                    r_seed <= pwdata;
                    r_rng  <= (pwdata == 32'd0) ? 32'd1 : pwdata;
                end
            endcase
        end else if (in_beat) begin
            r_rng <= rng_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_white <= rng_next[31:16];
            r_last  <= i_in.last_of_block;
        end
    end

    // Step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_issuing <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_state   <= S_RUN;
                        r_step    <= png_pkg::STEP_NORM;
                        r_issuing <= 1'b1;
                    end
                end
                S_RUN: begin
                    if (r_issuing) begin
                        r_step <= r_step + 4'd1;
                        if (r_step == png_pkg::STEP_SCALE) begin
                            r_issuing <= 1'b0;
                        end
                    end
                    if (dp_y_vld) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign dp_ctrl.issue = (r_state == S_RUN) && r_issuing;
    assign dp_ctrl.step  = r_step;

    png_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (dp_ctrl),
        .i_white     (r_white),
        .i_amplitude (r_amplitude),
        .o_y         (dp_y),
        .o_y_vld     (dp_y_vld)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_HOLD && out_free) begin
            r_out_valid <= 1'b1;
            r_sample    <= dp_y;
            r_block_end <= r_last;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.sample    = r_sample;
    assign o_out.block_end = r_block_end;

endmodule
`default_nettype wire

// ===== src/png_dp.sv =====
`default_nettype none
module png_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire png_pkg::t_dp_ctrl   i_ctrl,
    input  wire logic signed [15:0]  i_white,
    input  wire logic [14:0]         i_amplitude,
    output logic signed [15:0]       o_y,
    output logic                     o_y_vld
);

    logic signed [23:0] r_fs [png_pkg::NUM_STATES];
    logic signed [39:0] r_prod;
    logic [3:0]         r_ctag;
    logic               r_cvld;
    logic signed [24:0] r_tmp;
    logic signed [26:0] r_pink;
    logic [12:0]        r_amp;
    logic signed [15:0] r_y;
    logic               r_y_vld;

    logic [3:0]         issue_k;
    logic [3:0]         cons_k;
    logic signed [23:0] op_a;
    logic signed [15:0] op_b;
    logic signed [15:0] pink_sat;
    logic signed [24:0] sh;
    logic signed [23:0] new_state;

    assign issue_k = i_ctrl.step - 4'd1;
    assign cons_k  = r_ctag - 4'd1;

    // Clamp the filter sum to 16-bit signed
    always_comb begin
        if (r_pink > 27'sd32767) begin
            pink_sat = 16'sh7FFF;
        end else if (r_pink < -27'sd32768) begin
            pink_sat = -16'sh8000;
        end else begin
            pink_sat = r_pink[15:0];
        end
    end

    // Operand select for the shared multiplier
    always_comb begin
        op_b = png_pkg::coef(i_ctrl.step);
        priority if (i_ctrl.step == png_pkg::STEP_NORM) begin
            op_a = {9'd0, i_amplitude};
        end else if (i_ctrl.step == png_pkg::STEP_SCALE) begin
            op_a = 24'(pink_sat);
            op_b = {3'd0, r_amp};
        end else if (i_ctrl.step <= png_pkg::STEP_POLE_LAST && !issue_k[0]) begin
            op_a = r_fs[issue_k[3:1]];
        end else begin
            op_a = 24'(i_white);
        end
    end

    // Product after the Q15 arithmetic shift
    assign sh        = r_prod[39:15];
    assign new_state = 24'(r_tmp + sh);

    // Multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        r_ctag <= i_ctrl.step;
        if (!i_rst_n) begin
            r_cvld <= 1'b0;
        end else begin
            r_cvld <= i_ctrl.issue;
        end
    end

    // Accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < png_pkg::NUM_STATES; i++) begin
                r_fs[i] <= '0;
            end
            r_y_vld <= 1'b0;
        end else begin
            r_y_vld <= 1'b0;
            if (r_cvld) begin
                priority if (r_ctag == png_pkg::STEP_NORM) begin
                    r_amp  <= sh[12:0];
                    r_pink <= '0;
                end else if (r_ctag <= png_pkg::STEP_POLE_LAST) begin
                    if (!cons_k[0]) begin
                        r_tmp <= sh;
                    end else begin
                        r_fs[cons_k[3:1]] <= new_state;
                        r_pink <= r_pink + 27'(new_state);
                    end
                end else if (r_ctag == png_pkg::STEP_DIRECT) begin
                    r_pink <= r_pink + 27'(r_fs[png_pkg::DIFF_IDX]) + 27'(sh);
                end else if (r_ctag == png_pkg::STEP_DIFF) begin
                    r_fs[png_pkg::DIFF_IDX] <= sh[23:0];
                end else begin
                    r_y     <= sh[15:0];
                    r_y_vld <= 1'b1;
                end
            end
        end
    end

    assign o_y     = r_y;
    assign o_y_vld = r_y_vld;

endmodule
`default_nettype wire
